[hw/rtl/reorder_buffer_with_memory_checks_top_assert.svh]
// Assertion macros shared by the reorder buffer checker.
`ifndef REORDER_BUFFER_WITH_MEMORY_CHECKS_TOP_ASSERT_SVH
`define REORDER_BUFFER_WITH_MEMORY_CHECKS_TOP_ASSERT_SVH
// Implication checked at every rising clock edge outside reset.
`define ROB_ASSERT_IMP(lbl, clk_s, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ROB_ASSERT_NXT(lbl, clk_s, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

[hw/rtl/rob_pkg.sv]
// Package with the reorder buffer's constants and types.
`timescale 1ns / 1ps
package rob_pkg;
	localparam int ROB_ENTRIES = 16;
	localparam logic [1:0] STATE_COMMITTED = 2'd3;
	localparam logic [31:0] ROB_UNKNOWN = 32'hFFFF_FFFF;

	localparam logic [2:0] FN_PUSH = 3'd0;
	localparam logic [2:0] FN_POP = 3'd1;
	localparam logic [2:0] FN_UPD = 3'd2;
	localparam logic [2:0] FN_UPD_DST = 3'd3;
	localparam logic [2:0] FN_SET_DST = 3'd4;
	localparam logic [2:0] FN_FLUSH = 3'd5;
	localparam logic [2:0] FN_QUERY = 3'd6;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;
	localparam logic [1:0] ST_ABSENT = 2'd3;

	typedef struct packed {
		logic is_mem;
		logic [1:0] state;
		logic [31:0] value;
		logic [31:0] cycle;
		logic [31:0] dest;
	} rob_entry_t;

	// Scan token passed down the cell row during a query.
	typedef struct packed {
		logic active;
		logic known;
		logic noconf;
		logic [31:0] dest;
	} rob_scan_t;
endpackage

[hw/rtl/rob_cell.sv]
// One slot of the reorder buffer; it also advances the query scan by one slot.
`timescale 1ns / 1ps
module rob_cell (
	input logic clk,
	input logic wr_en,
	input rob_pkg::rob_entry_t wr_data,
	input logic older,
	input rob_pkg::rob_scan_t scan_in,
	output rob_pkg::rob_entry_t entry,
	output rob_pkg::rob_scan_t scan_out
);
	import rob_pkg::*;
	rob_entry_t entry_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			entry_q <= wr_data;
		end
	end

	assign entry = entry_q;

	always_comb begin
		scan_out = scan_in;
		if (scan_in.active && older && entry_q.is_mem) begin
			if (entry_q.dest == ROB_UNKNOWN) begin
				scan_out.known = 1'b0;
			end
			if (entry_q.dest == scan_in.dest && entry_q.state != STATE_COMMITTED) begin
				scan_out.noconf = 1'b0;
			end
		end
	end
endmodule

[hw/rtl/reorder_buffer_with_memory_checks_top.sv]
// Top level of the reorder buffer with memory-ordering checks.
// Usage: raise start with func and the operand ports while busy is low; the
// item is taken at that edge. Exactly one result follows, marked by done,
// which stays high for one cycle; the receiver cannot stall it.
// Push, pop, update, set destination, flush, items whose id is absent and the
// unused code give their result in the cycle right after the accepting edge.
// A query on a present id walks a token along the row of slot cells, one slot
// per cycle starting at the head, and its result shows once the token has
// passed every slot. busy is high from acceptance until the result is shown.
// A new item may be started in the cycle in which done is high.
// Reset clears head pointer, count and slot valid bits; slot payload is
// left as is and is written on push before it can be read.
// full_res, empty_res and occupancy report the buffer after the item.
`timescale 1ns / 1ps
module reorder_buffer_with_memory_checks_top #(
	parameter int ENTRIES = rob_pkg::ROB_ENTRIES
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	output logic done,
	input logic [2:0] func,
	input logic [3:0] entry_id,
	input logic is_mem,
	input logic [1:0] state_in,
	input logic signed [31:0] destination_in,
	input logic signed [31:0] value_in,
	input logic signed [31:0] cycle_in,
	output logic [1:0] status,
	output logic [3:0] result_id,
	output logic signed [31:0] value_out,
	output logic signed [31:0] destination_out,
	output logic [1:0] state_out,
	output logic signed [31:0] cycle_out,
	output logic is_mem_out,
	output logic addresses_known,
	output logic no_conflicting_older,
	output logic full_res,
	output logic empty_res,
	output logic [4:0] occupancy
);
	import rob_pkg::*;
	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CW = $clog2(ENTRIES + 1);
	localparam logic [CW-1:0] FULLC = CW'(ENTRIES);

	logic [ENTRIES-1:0] valid_q;
	logic [IW-1:0] head_q;
	logic [CW-1:0] count_q;
	logic busy_q, scan_q;
	logic [CW-1:0] step_q;
	logic [IW-1:0] qage_q;
	logic [1:0] status_q;
	logic [3:0] rid_q;
	rob_entry_t res_q;
	logic known_q, noconf_q, done_q;

	// Per-slot signals.
	logic [ENTRIES-1:0] wr_en, older;
	rob_entry_t wr_data [ENTRIES];
	rob_entry_t entry [ENTRIES];
	rob_scan_t scan_in [ENTRIES];
	rob_scan_t scan_out [ENTRIES];

	// Scan token register: every cell sees it; only the cell at the current scan slot may change it.
	rob_scan_t tok_q;
	logic [IW-1:0] scan_slot;

	function automatic logic [IW-1:0] wrap(input logic [IW:0] v);
		logic [IW:0] r;
		r = (v >= (IW+1)'(ENTRIES)) ? v - (IW+1)'(ENTRIES) : v;
		return r[IW-1:0];
	endfunction

	logic acc;
	logic in_range;
	logic [IW-1:0] id_s, age_id;
	logic present;
	logic [IW-1:0] tail;

	assign acc = start && !busy_q;
	assign in_range = ({28'd0, entry_id} < 32'(ENTRIES));
	assign id_s = entry_id[IW-1:0];
	assign age_id = wrap({1'b0, id_s} + (IW+1)'(ENTRIES) - {1'b0, head_q});
	assign present = in_range && ({1'b0, age_id} < (IW+1)'(count_q)) && valid_q[id_s];
	assign tail = wrap({1'b0, head_q} + (IW+1)'(count_q));
	assign scan_slot = wrap({1'b0, head_q} + (IW+1)'(step_q));

	genvar g;
	generate
		for (g = 0; g < ENTRIES; g++) begin : g_cell
			assign scan_in[g] = tok_q;
			assign older[g] = (IW'(g) == scan_slot) && (step_q < CW'(qage_q));
			always_comb begin
				wr_en[g] = 1'b0;
				wr_data[g] = entry[g];
				if (acc && func == FN_PUSH && count_q < FULLC && tail == IW'(g)) begin
					wr_en[g] = 1'b1;
					wr_data[g] = '{is_mem: is_mem, state: state_in, value: ROB_UNKNOWN,
						cycle: ROB_UNKNOWN, dest: destination_in};
				end else if (acc && present && id_s == IW'(g) &&
						(func == FN_UPD || func == FN_UPD_DST || func == FN_SET_DST)) begin
					wr_en[g] = 1'b1;
					if (func != FN_SET_DST) begin
						wr_data[g].value = value_in;
						wr_data[g].cycle = cycle_in;
						wr_data[g].state = state_in;
					end
					if (func != FN_UPD) begin
						wr_data[g].dest = destination_in;
					end
				end
			end
			rob_cell u_cell (
				.clk(clk), .wr_en(wr_en[g]), .wr_data(wr_data[g]), .older(older[g]),
				.scan_in(scan_in[g]), .entry(entry[g]), .scan_out(scan_out[g])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			head_q <= '0;
			count_q <= '0;
			busy_q <= 1'b0;
			scan_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
			tok_q <= '0;
			qage_q <= '0;
			status_q <= ST_OK;
			rid_q <= '0;
			res_q <= '0;
			known_q <= 1'b0;
			noconf_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (scan_q) begin
				tok_q <= scan_out[scan_slot];
				if (step_q == FULLC - CW'(1)) begin
					scan_q <= 1'b0;
					busy_q <= 1'b0;
					done_q <= 1'b1;
					known_q <= scan_out[scan_slot].known;
					noconf_q <= scan_out[scan_slot].noconf;
				end else begin
					step_q <= step_q + CW'(1);
				end
			end else if (acc) begin
				status_q <= ST_OK;
				rid_q <= entry_id;
				res_q <= '0;
				known_q <= 1'b0;
				noconf_q <= 1'b0;
				done_q <= 1'b1;
				case (func)
					FN_PUSH: begin
						rid_q <= '0;
						if (count_q >= FULLC) begin
							status_q <= ST_FULL;
						end else begin
							valid_q[tail] <= 1'b1;
							count_q <= count_q + CW'(1);
							rid_q <= 4'(tail);
						end
					end
					FN_POP: begin
						rid_q <= '0;
						if (count_q == '0) begin
							status_q <= ST_EMPTY;
						end else begin
							res_q <= entry[head_q];
							valid_q[head_q] <= 1'b0;
							head_q <= wrap({1'b0, head_q} + (IW+1)'(1));
							count_q <= count_q - CW'(1);
							rid_q <= 4'(head_q);
						end
					end
					FN_UPD, FN_UPD_DST, FN_SET_DST, FN_FLUSH, FN_QUERY: begin
						if (!present) begin
							status_q <= ST_ABSENT;
						end else if (func == FN_FLUSH) begin
							for (int k = 0; k < ENTRIES; k++) begin
								if (wrap({1'b0, IW'(k)} + (IW+1)'(ENTRIES) - {1'b0, head_q})
										> age_id) begin
									valid_q[k] <= 1'b0;
								end
							end
							count_q <= CW'(age_id) + CW'(1);
						end else if (func == FN_QUERY) begin
							res_q <= entry[id_s];
							qage_q <= age_id;
							step_q <= '0;
							tok_q <= '{active: 1'b1, known: 1'b1, noconf: 1'b1,
								dest: entry[id_s].dest};
							scan_q <= 1'b1;
							busy_q <= 1'b1;
							done_q <= 1'b0;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign status = status_q;
	assign result_id = rid_q;
	assign value_out = res_q.value;
	assign destination_out = res_q.dest;
	assign state_out = res_q.state;
	assign cycle_out = res_q.cycle;
	assign is_mem_out = res_q.is_mem;
	assign addresses_known = known_q;
	assign no_conflicting_older = noconf_q;
	assign full_res = (count_q == FULLC);
	assign empty_res = (count_q == '0);
	assign occupancy = 5'(count_q);
endmodule

[hw/rtl/rob_checker.sv]
// Port-level checker for the reorder buffer, bound to the top level.
`timescale 1ns / 1ps
`include "reorder_buffer_with_memory_checks_top_assert.svh"
module rob_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input logic full_res,
	input logic empty_res,
	input logic [4:0] occupancy,
	input logic [1:0] status
);
	import rob_pkg::*;
	`ROB_ASSERT_IMP(a_full_empty, clk, arst_n, 1'b1, !(full_res && empty_res))
	`ROB_ASSERT_IMP(a_empty_occ, clk, arst_n, 1'b1, empty_res == (occupancy == 5'd0))
	`ROB_ASSERT_NXT(a_idle_start_done, clk, arst_n, start && !busy, done || busy)
	`ROB_ASSERT_IMP(a_full_no_push_err, clk, arst_n, done && status == ST_FULL, full_res)
endmodule

bind reorder_buffer_with_memory_checks_top rob_checker u_rob_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
	.full_res(full_res), .empty_res(empty_res), .occupancy(occupancy), .status(status)
);

[tb/reorder_buffer_with_memory_checks_top_test.sv]
// Self-checking testbench for the reorder buffer with memory-ordering checks.
`timescale 1ns / 1ps
module reorder_buffer_with_memory_checks_top_test;
	import rob_pkg::*;

	typedef struct {
		logic [2:0] func;
		logic [3:0] entry_id;
		logic is_mem;
		logic [1:0] state_in;
		logic [31:0] destination_in;
		logic [31:0] value_in;
		logic [31:0] cycle_in;
	} rob_cmd_t;

	typedef struct {
		logic [1:0] status;
		logic [3:0] result_id;
		logic [31:0] value_out;
		logic [31:0] destination_out;
		logic [1:0] state_out;
		logic [31:0] cycle_out;
		logic is_mem_out;
		logic addresses_known;
		logic no_conflicting_older;
		logic full_res;
		logic empty_res;
		logic [4:0] occupancy;
	} rob_reply_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy, done;
	logic [2:0] func = '0;
	logic [3:0] entry_id = '0;
	logic is_mem = 1'b0;
	logic [1:0] state_in = '0;
	logic signed [31:0] destination_in = '0;
	logic signed [31:0] value_in = '0;
	logic signed [31:0] cycle_in = '0;
	logic [1:0] status;
	logic [3:0] result_id;
	logic signed [31:0] value_out, destination_out, cycle_out;
	logic [1:0] state_out;
	logic is_mem_out, addresses_known, no_conflicting_older, full_res, empty_res;
	logic [4:0] occupancy;

	reorder_buffer_with_memory_checks_top uut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Shadow copy of the buffer contents.
	rob_entry_t shadow_slot [ROB_ENTRIES];
	logic shadow_valid [ROB_ENTRIES];
	int unsigned shadow_head, shadow_count;

	rob_cmd_t pending_cmds[$];
	rob_reply_t expected_replies[$];
	int errors = 0;
	int accepted = 0;
	int checked = 0;
	int queries = 0;
	bit gaps_on = 1'b1;
	bit stimulus_done = 1'b0;

	// busy as sampled at the last rising edge decides whether start was taken.
	logic busy_at_edge = 1'b0;

	function automatic int unsigned age_of(int unsigned id);
		return (id + ROB_ENTRIES - shadow_head) % ROB_ENTRIES;
	endfunction

	function automatic rob_reply_t predict_reply(rob_cmd_t c);
		rob_reply_t r;
		int unsigned s, a, keep;
		bit live;
		r = '{default: '0};
		r.result_id = c.entry_id;
		live = age_of(c.entry_id) < shadow_count && shadow_valid[c.entry_id];
		case (c.func)
			FN_PUSH: begin
				r.result_id = '0;
				if (shadow_count >= ROB_ENTRIES) begin
					r.status = ST_FULL;
				end else begin
					s = (shadow_head + shadow_count) % ROB_ENTRIES;
					shadow_valid[s] = 1'b1;
					shadow_slot[s] = '{is_mem: c.is_mem, state: c.state_in,
						value: ROB_UNKNOWN, cycle: ROB_UNKNOWN, dest: c.destination_in};
					shadow_count++;
					r.result_id = 4'(s);
				end
			end
			FN_POP: begin
				r.result_id = '0;
				if (shadow_count == 0) begin
					r.status = ST_EMPTY;
				end else begin
					s = shadow_head;
					r.value_out = shadow_slot[s].value;
					r.destination_out = shadow_slot[s].dest;
					r.state_out = shadow_slot[s].state;
					r.cycle_out = shadow_slot[s].cycle;
					r.is_mem_out = shadow_slot[s].is_mem;
					shadow_valid[s] = 1'b0;
					shadow_head = (s + 1) % ROB_ENTRIES;
					shadow_count--;
					r.result_id = 4'(s);
				end
			end
			FN_UPD, FN_UPD_DST, FN_SET_DST, FN_FLUSH, FN_QUERY: begin
				if (!live) begin
					r.status = ST_ABSENT;
				end else if (c.func == FN_UPD || c.func == FN_UPD_DST) begin
					shadow_slot[c.entry_id].value = c.value_in;
					shadow_slot[c.entry_id].cycle = c.cycle_in;
					shadow_slot[c.entry_id].state = c.state_in;
					if (c.func == FN_UPD_DST)
						shadow_slot[c.entry_id].dest = c.destination_in;
				end else if (c.func == FN_SET_DST) begin
					shadow_slot[c.entry_id].dest = c.destination_in;
				end else if (c.func == FN_FLUSH) begin
					keep = age_of(c.entry_id) + 1;
					for (int unsigned i = keep; i < shadow_count; i++)
						shadow_valid[(shadow_head + i) % ROB_ENTRIES] = 1'b0;
					shadow_count = keep;
				end else begin
					s = c.entry_id;
					a = age_of(s);
					r.value_out = shadow_slot[s].value;
					r.destination_out = shadow_slot[s].dest;
					r.state_out = shadow_slot[s].state;
					r.cycle_out = shadow_slot[s].cycle;
					r.is_mem_out = shadow_slot[s].is_mem;
					r.addresses_known = 1'b1;
					r.no_conflicting_older = 1'b1;
					for (int unsigned i = 0; i < a; i++) begin
						rob_entry_t e;
						e = shadow_slot[(shadow_head + i) % ROB_ENTRIES];
						if (e.is_mem) begin
							if (e.dest == ROB_UNKNOWN)
								r.addresses_known = 1'b0;
							if (e.dest == shadow_slot[s].dest && e.state != STATE_COMMITTED)
								r.no_conflicting_older = 1'b0;
						end
					end
				end
			end
			default: ;
		endcase
		r.full_res = shadow_count == ROB_ENTRIES;
		r.empty_res = shadow_count == 0;
		r.occupancy = 5'(shadow_count);
		return r;
	endfunction

	// A small pool of destinations makes conflicts between entries common.
	function automatic logic [31:0] pick_dest();
		case ($urandom_range(0, 5))
			0: return ROB_UNKNOWN;
			1: return 32'h7FFF_FFFF;
			2: return $urandom;
			default: return $urandom_range(0, 3);
		endcase
	endfunction

	function automatic logic [3:0] pick_live_id();
		if (shadow_count == 0 || $urandom_range(0, 9) == 0)
			return 4'($urandom);
		return 4'((shadow_head + $urandom_range(0, shadow_count - 1)) % ROB_ENTRIES);
	endfunction

	task automatic queue_cmd(logic [31:0] f, logic [31:0] id, logic [31:0] m,
			logic [31:0] st, logic [31:0] d, logic [31:0] v, logic [31:0] cy);
		pending_cmds.insert(pending_cmds.size(), '{f[2:0], id[3:0], m[0], st[1:0], d, v, cy});
	endtask

	// Driver: a new item may follow the one whose result is being shown.
	always @(negedge clk) begin
		rob_cmd_t c;
		if (arst_n) begin
			if ((!start || !busy_at_edge) && pending_cmds.size() != 0 &&
					!(gaps_on && $urandom_range(0, 99) < 28)) begin
				c = pending_cmds.pop_front();
				start <= 1'b1;
				func <= c.func;
				entry_id <= c.entry_id;
				is_mem <= c.is_mem;
				state_in <= c.state_in;
				destination_in <= c.destination_in;
				value_in <= c.value_in;
				cycle_in <= c.cycle_in;
			end else if (start && !busy_at_edge) begin
				start <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		busy_at_edge <= busy;
		if (arst_n && start && !busy) begin
			expected_replies.insert(expected_replies.size(), predict_reply('{func, entry_id,
				is_mem, state_in, destination_in, value_in, cycle_in}));
			accepted++;
			if (func == FN_QUERY)
				queries++;
		end
	end

	task automatic report_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
		if (exp_v !== got_v) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, got_v);
			errors++;
		end
	endtask

	// Monitor: a result is valid for the single cycle in which done is high.
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_replies.size() == 0) begin
				$display("%0t: result with nothing expected, actual status %0d id %0d",
					$time, status, result_id);
				errors++;
			end else begin
				rob_reply_t e;
				e = expected_replies.pop_front();
				report_field("status", e.status, status);
				report_field("result_id", e.result_id, result_id);
				report_field("value_out", e.value_out, value_out);
				report_field("destination_out", e.destination_out, destination_out);
				report_field("state_out", e.state_out, state_out);
				report_field("cycle_out", e.cycle_out, cycle_out);
				report_field("is_mem_out", e.is_mem_out, is_mem_out);
				report_field("addresses_known", e.addresses_known, addresses_known);
				report_field("no_conflicting_older", e.no_conflicting_older,
					no_conflicting_older);
				report_field("full_res", e.full_res, full_res);
				report_field("empty_res", e.empty_res, empty_res);
				report_field("occupancy", e.occupancy, occupancy);
				checked++;
			end
		end
	end

	initial begin
		int unsigned pick;
		for (int i = 0; i < ROB_ENTRIES; i++)
			shadow_valid[i] = 1'b0;
		shadow_head = 0;
		shadow_count = 0;
		repeat (3) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// Directed: errors on an empty buffer, fill to full, overflow, every op.
		queue_cmd(FN_POP, 4'hF, 1, 3, ROB_UNKNOWN, 32'h8000_0000, 0);
		queue_cmd(FN_QUERY, 4'd0, 0, 0, 0, 0, 0);
		queue_cmd(3'd7, 4'd5, 1, 2, 0, 0, 0);
		for (int i = 0; i < ROB_ENTRIES; i++)
			queue_cmd(FN_PUSH, 4'hF, i % 2, i % 4,
				(i == 1) ? ROB_UNKNOWN : (i == 2 ? 32'h7FFF_FFFF : i % 3), 0, 0);
		queue_cmd(FN_PUSH, 0, 1, 3, 5, 0, 0);
		queue_cmd(FN_UPD, 4'd3, 0, 3, 0, 32'h8000_0000, ROB_UNKNOWN);
		queue_cmd(FN_UPD_DST, 4'd4, 0, 0, 32'd1, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		queue_cmd(FN_SET_DST, 4'd1, 0, 0, 32'd0, 0, 0);
		queue_cmd(FN_QUERY, 4'd15, 0, 0, 0, 0, 0);
		queue_cmd(FN_QUERY, 4'd0, 0, 0, 0, 0, 0);
		queue_cmd(FN_FLUSH, 4'd9, 0, 0, 0, 0, 0);
		queue_cmd(FN_QUERY, 4'd12, 0, 0, 0, 0, 0);
		queue_cmd(FN_POP, 0, 0, 0, 0, 0, 0);
		queue_cmd(FN_QUERY, 4'd0, 0, 0, 0, 0, 0);
		wait (pending_cmds.size() == 0 && expected_replies.size() == 0);

		// Pause until every result is in, then go on at full rate for a stretch.
		gaps_on = 1'b0;
		for (int n = 0; n < 400; n++) begin
			if (n == 60)
				wait (pending_cmds.size() == 0 && expected_replies.size() == 0);
			if (n == 60)
				gaps_on = 1'b1;
			// Wait until the driver has taken the last queued item before queuing the next.
			wait (pending_cmds.size() == 0);
			pick = $urandom_range(0, 99);
			if (pick < 30)
				queue_cmd(FN_PUSH, $urandom, $urandom, $urandom, pick_dest(), $urandom,
					$urandom);
			else if (pick < 45)
				queue_cmd(FN_POP, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
			else if (pick < 57)
				queue_cmd($urandom_range(0, 1) ? FN_UPD : FN_UPD_DST, pick_live_id(),
					$urandom, $urandom, pick_dest(), $urandom,
					$urandom_range(0, 1) ? ROB_UNKNOWN : $urandom);
			else if (pick < 65)
				queue_cmd(FN_SET_DST, pick_live_id(), 0, 0, pick_dest(), 0, 0);
			else if (pick < 70)
				queue_cmd(FN_FLUSH, pick_live_id(), 0, 0, 0, 0, 0);
			else if (pick < 98)
				queue_cmd(FN_QUERY, pick_live_id(), $urandom, $urandom, $urandom, $urandom,
					$urandom);
			else
				queue_cmd(3'd7, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
			@(posedge clk);
		end
		wait (pending_cmds.size() == 0 && expected_replies.size() == 0);
		repeat (3 * ROB_ENTRIES) @(posedge clk);
		$display("Accepted %0d items (%0d queries); %0d results checked field by field.",
			accepted, queries, checked);
		if (errors == 0 && expected_replies.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Timeout: %0d results still expected", expected_replies.size());
		$display("Test completed with failures");
		$finish;
	end
endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/rob_pkg.sv
hw/rtl/rob_cell.sv
hw/rtl/reorder_buffer_with_memory_checks_top.sv
hw/rtl/rob_checker.sv
tb/reorder_buffer_with_memory_checks_top_test.sv
